/* rtl/cprt_pkg.sv */
// Package for the CAN poll/reply tracker.
// Holds item, result and configuration types, codes and group tables.
// No dependencies.
package cprt_pkg;

  localparam int unsigned TOKEN_W    = 11;
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned ID_W       = 29;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned GROUP_W    = 2;
  localparam int unsigned PAYLOAD_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [NODE_W-1:0] NODE_MAX = 4'd14;

  // Identifier field codes
  localparam logic [2:0] KIND_REQUEST  = 3'd1;
  localparam logic [2:0] KIND_REPLY    = 3'd2;
  localparam logic [3:0] TABLE_REQUEST = 4'd5;
  localparam logic [3:0] TABLE_REPLY   = 4'd6;
  localparam logic [7:0] CMD_READ      = 8'd6;

  // Fault masks
  localparam logic [7:0] STATUS_FAULT_MASK  = 8'h1C;
  localparam logic [7:0] CHANNEL_FAULT_MASK = 8'h3E;
  localparam logic [7:0] STATUS_OK_BYTE     = 8'h01;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FRAME = 1'b1
  } op_t;

  typedef enum logic [GROUP_W-1:0] {
    GRP_PEDAL   = 2'd0,
    GRP_CURRENT = 2'd1,
    GRP_STATUS  = 2'd2,
    GRP_CHANNEL = 2'd3
  } group_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_ENABLE    = 3'd0,
    REG_OWN_NODE       = 3'd1,
    REG_REMOTE_NODE    = 3'd2,
    REG_REPLY_DEADLINE = 3'd3,
    REG_POLL_INTERVAL  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              poll_enable;
    logic [NODE_W-1:0] own_node;
    logic [NODE_W-1:0] remote_node;
    logic [MS_W-1:0]   reply_deadline;
    logic [MS_W-1:0]   poll_gap;
    logic              poll_ok;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_data;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;
    logic              fault_flag;
  } decode_t;

  typedef struct packed {
    logic                 request_valid;
    logic [ID_W-1:0]      request_id;
    logic [PAYLOAD_W-1:0] request_payload;
    logic                 reply_accepted;
    logic [GROUP_W-1:0]   reply_group;
    decode_t              words;
  } result_t;

  // Register-map offset of each group
  function automatic logic [TOKEN_W-1:0] group_offset(input logic [GROUP_W-1:0] grp);
    logic [TOKEN_W-1:0] off;
    case (grp)
      GRP_PEDAL:   off = 11'd0;
      GRP_CURRENT: off = 11'd64;
      GRP_STATUS:  off = 11'd76;
      GRP_CHANNEL: off = 11'd60;
      default:     off = 11'd0;
    endcase
    return off;
  endfunction

  // Reply payload length of each group
  function automatic logic [LEN_W-1:0] group_length(input logic [GROUP_W-1:0] grp);
    logic [LEN_W-1:0] len;
    case (grp)
      GRP_PEDAL:   len = 4'd8;
      GRP_CURRENT: len = 4'd4;
      GRP_STATUS:  len = 4'd8;
      GRP_CHANNEL: len = 4'd4;
      default:     len = 4'd8;
    endcase
    return len;
  endfunction

  // Pack a 29-bit extended identifier
  function automatic logic [ID_W-1:0] pack_id(input logic [TOKEN_W-1:0] off,
                                              input logic [2:0]         kind,
                                              input logic [NODE_W-1:0]  src,
                                              input logic [NODE_W-1:0]  dst,
                                              input logic [3:0]         tbl);
    return {off, kind, src, dst, tbl, 3'b000};
  endfunction

endpackage

/* rtl/cprt_if.sv */
// Valid/ready channel interfaces for the CAN poll/reply tracker.
// Depends on cprt_pkg for field widths.
interface cprt_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [cprt_pkg::TIME_W-1:0]     now_ms;
  logic [cprt_pkg::ID_W-1:0]       frame_id;
  logic [cprt_pkg::LEN_W-1:0]      frame_len;
  logic [cprt_pkg::DATA_W-1:0]     frame_data;

  modport source (output valid, operation, now_ms, frame_id, frame_len, frame_data,
                  input ready);
  modport sink (input valid, operation, now_ms, frame_id, frame_len, frame_data,
                output ready);
endinterface

interface cprt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            request_valid;
  logic [cprt_pkg::ID_W-1:0]       request_id;
  logic [cprt_pkg::PAYLOAD_W-1:0]  request_payload;
  logic                            reply_accepted;
  logic [cprt_pkg::GROUP_W-1:0]    reply_group;
  logic [cprt_pkg::WORD_W-1:0]     word_a;
  logic [cprt_pkg::WORD_W-1:0]     word_b;
  logic [cprt_pkg::WORD_W-1:0]     word_c;
  logic [cprt_pkg::WORD_W-1:0]     word_d;
  logic                            fault_flag;

  modport source (output valid, request_valid, request_id, request_payload,
                  reply_accepted, reply_group, word_a, word_b, word_c, word_d,
                  fault_flag, input ready);
  modport sink (input valid, request_valid, request_id, request_payload,
                reply_accepted, reply_group, word_a, word_b, word_c, word_d,
                fault_flag, output ready);
endinterface

/* rtl/cprt_cfg_regs.sv */
// Configuration register file of the CAN poll/reply tracker.
// Depends on cprt_pkg; produces the cfg_t bundle with the poll-allowed flag.
module cprt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cprt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cprt_pkg::CFG_DATA_W-1:0] cfg_data,
  output cprt_pkg::cfg_t                  cfg
);

  logic                          poll_enable;
  logic [cprt_pkg::NODE_W-1:0]   own_node;
  logic [cprt_pkg::NODE_W-1:0]   remote_node;
  logic [cprt_pkg::MS_W-1:0]     reply_deadline;
  logic [cprt_pkg::MS_W-1:0]     poll_gap;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_enable    <= 1'b0;
      own_node       <= '0;
      remote_node    <= '0;
      reply_deadline <= '0;
      poll_gap       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cprt_pkg::REG_POLL_ENABLE:    poll_enable    <= cfg_data[0];
        cprt_pkg::REG_OWN_NODE:       own_node       <= cfg_data[cprt_pkg::NODE_W-1:0];
        cprt_pkg::REG_REMOTE_NODE:    remote_node    <= cfg_data[cprt_pkg::NODE_W-1:0];
        cprt_pkg::REG_REPLY_DEADLINE: reply_deadline <= cfg_data[cprt_pkg::MS_W-1:0];
        cprt_pkg::REG_POLL_INTERVAL:  poll_gap       <= cfg_data[cprt_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Polling needs valid, distinct nodes and a nonzero deadline
  always_comb begin
    cfg.poll_enable    = poll_enable;
    cfg.own_node       = own_node;
    cfg.remote_node    = remote_node;
    cfg.reply_deadline = reply_deadline;
    cfg.poll_gap       = poll_gap;
    cfg.poll_ok        = poll_enable && (reply_deadline != '0) &&
                         (own_node <= cprt_pkg::NODE_MAX) &&
                         (remote_node <= cprt_pkg::NODE_MAX) &&
                         (own_node != remote_node);
  end

endmodule

/* rtl/cprt_reply_decode.sv */
// Reply payload decoder of the CAN poll/reply tracker.
// Depends on cprt_pkg; turns one group's payload into words and a fault flag.
module cprt_reply_decode (
  input  logic [cprt_pkg::GROUP_W-1:0] group,
  input  logic [cprt_pkg::DATA_W-1:0]  frame_data,
  output cprt_pkg::decode_t            dec
);

  logic [7:0] b0, b1, b4, b5, b7;

  always_comb begin
    b0 = frame_data[7:0];
    b1 = frame_data[15:8];
    b4 = frame_data[39:32];
    b5 = frame_data[47:40];
    b7 = frame_data[63:56];
    dec = '0;
    case (group)
      // Four little-endian sensor words
      cprt_pkg::GRP_PEDAL: begin
        dec.word_a = frame_data[15:0];
        dec.word_b = frame_data[31:16];
        dec.word_c = frame_data[47:32];
        dec.word_d = frame_data[63:48];
      end
      // Raw motor current
      cprt_pkg::GRP_CURRENT: begin
        dec.word_a = frame_data[15:0];
      end
      // Status fault: nonzero code, bad state byte or error bits
      cprt_pkg::GRP_STATUS: begin
        dec.fault_flag = (frame_data[15:0] != '0) || (b4 != cprt_pkg::STATUS_OK_BYTE) ||
                         (b5 != '0) || ((b7 & cprt_pkg::STATUS_FAULT_MASK) != '0);
      end
      // Channel fault bits
      cprt_pkg::GRP_CHANNEL: begin
        dec.fault_flag = ((b0 & cprt_pkg::CHANNEL_FAULT_MASK) != '0) || (b1 != '0);
      end
      default: dec = '0;
    endcase
  end

endmodule

/* rtl/cprt_engine.sv */
// Poll/reply engine: input register, state update and result register.
// Depends on cprt_pkg, cprt_if and cprt_reply_decode.
module cprt_engine (
  input  logic           clk,
  input  logic           rst,
  input  cprt_pkg::cfg_t cfg,
  cprt_in_if.sink        item,
  cprt_out_if.source     result
);

  // Input register
  cprt_pkg::item_t in_q;
  logic            in_q_valid;

  // Result register
  cprt_pkg::result_t out_q;
  logic              out_valid;

  // Tracker state
  logic                         reply_pending;
  logic [cprt_pkg::TOKEN_W-1:0] seq_token;
  logic [cprt_pkg::GROUP_W-1:0] group_index;
  logic [cprt_pkg::TIME_W-1:0]  last_poll_time;
  logic [cprt_pkg::ID_W-1:0]    expected_reply_id;

  logic                         reply_pending_next;
  logic [cprt_pkg::TOKEN_W-1:0] seq_token_next;
  logic [cprt_pkg::GROUP_W-1:0] group_index_next;
  logic [cprt_pkg::TIME_W-1:0]  last_poll_time_next;
  logic [cprt_pkg::ID_W-1:0]    expected_reply_id_next;
  cprt_pkg::result_t            res_next;

  logic                         advance;
  logic [cprt_pkg::TIME_W-1:0]  elapsed;
  logic                         in_time;
  logic                         expire;
  logic [cprt_pkg::TOKEN_W-1:0] token_now;
  logic                         issue;
  logic                         accept;
  logic [cprt_pkg::LEN_W-1:0]   grp_len;
  cprt_pkg::decode_t            dec;

  // Move the held transaction on when the result register is free
  assign advance    = in_q_valid && (!out_valid || result.ready);
  assign item.ready = !in_q_valid || advance;

  // Capture a transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item.ready) begin
      in_q_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      in_q.operation  <= item.operation;
      in_q.now_ms     <= item.now_ms;
      in_q.frame_id   <= item.frame_id;
      in_q.frame_len  <= item.frame_len;
      in_q.frame_data <= item.frame_data;
    end
  end

  cprt_reply_decode u_decode (
    .group      (group_index),
    .frame_data (in_q.frame_data),
    .dec        (dec)
  );

  // Tick and reply decisions
  always_comb begin
    elapsed   = in_q.now_ms - last_poll_time;
    in_time   = elapsed <= {{(cprt_pkg::TIME_W-cprt_pkg::MS_W){1'b0}}, cfg.reply_deadline};
    grp_len   = cprt_pkg::group_length(group_index);
    expire    = 1'b0;
    issue     = 1'b0;
    accept    = 1'b0;
    token_now = seq_token;

    if (in_q.operation == cprt_pkg::OP_TICK) begin
      if (cfg.poll_ok && !(reply_pending && in_time)) begin
        expire    = reply_pending;
        token_now = reply_pending ? seq_token + 1'b1 : seq_token;
        issue     = elapsed >=
                    {{(cprt_pkg::TIME_W-cprt_pkg::MS_W){1'b0}}, cfg.poll_gap};
      end
    end else begin
      accept = cfg.poll_enable && reply_pending && (in_q.frame_id == expected_reply_id) &&
               (in_q.frame_len == grp_len) && in_time;
    end

    reply_pending_next     = reply_pending;
    seq_token_next         = seq_token;
    group_index_next       = group_index;
    last_poll_time_next    = last_poll_time;
    expected_reply_id_next = expected_reply_id;
    res_next               = '0;

    // Drop an overdue request
    if (expire) begin
      reply_pending_next = 1'b0;
      seq_token_next     = token_now;
    end

    // Send a read request and note the reply identifier
    if (issue) begin
      res_next.request_valid   = 1'b1;
      res_next.request_id      = cprt_pkg::pack_id(cprt_pkg::group_offset(group_index),
                                   cprt_pkg::KIND_REQUEST, cfg.own_node,
                                   cfg.remote_node, cprt_pkg::TABLE_REQUEST);
      res_next.request_payload = {cprt_pkg::CMD_READ, token_now[10:3], token_now[2:0],
                                  {1'b0, grp_len}};
      expected_reply_id_next   = cprt_pkg::pack_id(token_now, cprt_pkg::KIND_REPLY,
                                   cfg.remote_node, cfg.own_node, cprt_pkg::TABLE_REPLY);
      reply_pending_next       = 1'b1;
      last_poll_time_next      = in_q.now_ms;
    end

    // Decode a matching reply and advance token and group
    if (accept) begin
      res_next.reply_accepted = 1'b1;
      res_next.reply_group    = group_index;
      res_next.words          = dec;
      reply_pending_next      = 1'b0;
      seq_token_next          = seq_token + 1'b1;
      group_index_next        = group_index + 1'b1;
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      reply_pending     <= 1'b0;
      seq_token         <= '0;
      group_index       <= '0;
      last_poll_time    <= '0;
      expected_reply_id <= '0;
    end else begin
      if (advance) begin
        out_valid         <= 1'b1;
        reply_pending     <= reply_pending_next;
        seq_token         <= seq_token_next;
        group_index       <= group_index_next;
        last_poll_time    <= last_poll_time_next;
        expected_reply_id <= expected_reply_id_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.request_valid   = out_q.request_valid;
  assign result.request_id      = out_q.request_id;
  assign result.request_payload = out_q.request_payload;
  assign result.reply_accepted  = out_q.reply_accepted;
  assign result.reply_group     = out_q.reply_group;
  assign result.word_a          = out_q.words.word_a;
  assign result.word_b          = out_q.words.word_b;
  assign result.word_c          = out_q.words.word_c;
  assign result.word_d          = out_q.words.word_d;
  assign result.fault_flag      = out_q.words.fault_flag;

  // A result never carries both a request and a reply
  a_single_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.request_valid && out_q.reply_accepted))
    else $error("result carries both a request and a reply");

  // A sent request leaves a reply pending
  a_issue_pending: assert property (@(posedge clk) disable iff (rst)
    (advance && issue) |=> reply_pending)
    else $error("request sent without pending mark");

  // An accepted reply moves to the next group
  a_group_step: assert property (@(posedge clk) disable iff (rst)
    (advance && accept) |=> (group_index == $past(group_index) + 2'd1))
    else $error("group did not advance after reply");

  // State holds while no transaction is processed
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(seq_token) && $stable(group_index) && $stable(reply_pending)))
    else $error("tracker state changed without a transaction");

  // A held input transaction is not lost
  a_input_kept: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !advance) |=> in_q_valid)
    else $error("input transaction dropped");

endmodule

/* rtl/can_poll_reply_tracker_unit.sv */
// CAN poll/reply tracker, top level.
// An accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while results are taken (ready high);
// the state update is a single pass.
// Reset (synchronous, active high) clears the registers, the pending mark,
// token, group, poll time and expected identifier.
// Depends on cprt_pkg, cprt_if, cprt_cfg_regs and cprt_engine.
module can_poll_reply_tracker_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cprt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cprt_pkg::CFG_DATA_W-1:0] cfg_data,
  cprt_in_if.sink                         item,
  cprt_out_if.source                      result
);

  cprt_pkg::cfg_t cfg;

  cprt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cprt_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

endmodule

/* dv/tb_can_poll_reply_tracker_unit.sv */
// Self-checking bench for the CAN poll/reply tracker top level.
// Drives ticks and reply frames over cprt_in_if, checks every result on cprt_out_if.
// Depends on cprt_pkg, cprt_if and can_poll_reply_tracker_unit.
`timescale 1ns / 100ps

module tb_can_poll_reply_tracker_unit;

  typedef struct packed {
    logic                        en;
    logic [cprt_pkg::NODE_W-1:0] loc;
    logic [cprt_pkg::NODE_W-1:0] rem;
    logic [cprt_pkg::MS_W-1:0]   tmo;
    logic [cprt_pkg::MS_W-1:0]   ivl;
  } poll_regs_t;

  typedef struct packed {
    logic                         pend;
    logic [cprt_pkg::TOKEN_W-1:0] token;
    logic [cprt_pkg::GROUP_W-1:0] grp;
    logic [cprt_pkg::TIME_W-1:0]  last;
    logic [cprt_pkg::ID_W-1:0]    reply_id;
  } tracker_state_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [cprt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cprt_pkg::CFG_DATA_W-1:0] cfg_data;

  cprt_in_if  item_if ();
  cprt_out_if result_if ();

  can_poll_reply_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // Register copy, tracker state as seen at acceptance, and state as planned
  poll_regs_t     regs;
  tracker_state_t model_st;
  tracker_state_t plan_st;

  cprt_pkg::item_t   outbox_items [$];
  cprt_pkg::result_t due_results [$];
  cprt_pkg::item_t   on_wire;
  cprt_pkg::result_t next_due;

  int src_idle_pct;
  int sink_idle_pct;
  int queued_total;
  int counted_items;
  int accepted_items;
  int results_checked;
  int requests_seen;
  int replies_seen;
  int num_settings;
  int mismatches;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reply length of each register group
  function automatic logic [cprt_pkg::LEN_W-1:0] grp_len(
      input logic [cprt_pkg::GROUP_W-1:0] g);
    logic [cprt_pkg::LEN_W-1:0] len;
    case (g)
      cprt_pkg::GRP_PEDAL:   len = 4'd8;
      cprt_pkg::GRP_CURRENT: len = 4'd4;
      cprt_pkg::GRP_STATUS:  len = 4'd8;
      default:               len = 4'd4;
    endcase
    return len;
  endfunction

  // Apply one transaction to a tracker state and return the result it gives
  function automatic cprt_pkg::result_t advance_tracker(inout tracker_state_t s,
                                                        input poll_regs_t c,
                                                        input cprt_pkg::item_t it);
    cprt_pkg::result_t            r;
    logic [cprt_pkg::TIME_W-1:0]  elapsed;
    logic [cprt_pkg::GROUP_W-1:0] g;
    logic [cprt_pkg::DATA_W-1:0]  d;
    logic [cprt_pkg::TOKEN_W-1:0] off;
    logic                         issue;
    r = '0;
    g = s.grp;
    d = it.frame_data;
    elapsed = it.now_ms - s.last;
    if (it.operation == cprt_pkg::OP_TICK) begin
      // poll only with a usable node pair and a nonzero deadline
      if (c.en && c.tmo != '0 && c.loc <= cprt_pkg::NODE_MAX &&
          c.rem <= cprt_pkg::NODE_MAX && c.loc != c.rem) begin
        issue = 1'b1;
        if (s.pend) begin
          if (elapsed <= cprt_pkg::TIME_W'(c.tmo)) begin
            issue = 1'b0;
          end else begin
            // drop the overdue request
            s.pend = 1'b0;
            s.token = s.token + 1'b1;
          end
        end
        if (issue && elapsed >= cprt_pkg::TIME_W'(c.ivl)) begin
          case (g)
            cprt_pkg::GRP_PEDAL:   off = 11'd0;
            cprt_pkg::GRP_CURRENT: off = 11'd64;
            cprt_pkg::GRP_STATUS:  off = 11'd76;
            default:               off = 11'd60;
          endcase
          r.request_valid = 1'b1;
          r.request_id = {off, cprt_pkg::KIND_REQUEST, c.loc, c.rem,
                          cprt_pkg::TABLE_REQUEST, 3'b000};
          r.request_payload = {cprt_pkg::CMD_READ, s.token[10:3], s.token[2:0], 1'b0,
                               grp_len(g)};
          s.reply_id = {s.token, cprt_pkg::KIND_REPLY, c.rem, c.loc,
                        cprt_pkg::TABLE_REPLY, 3'b000};
          s.pend = 1'b1;
          s.last = it.now_ms;
        end
      end
    end else if (c.en && s.pend && it.frame_id == s.reply_id &&
                 it.frame_len == grp_len(g) &&
                 elapsed <= cprt_pkg::TIME_W'(c.tmo)) begin
      r.reply_accepted = 1'b1;
      r.reply_group = g;
      case (g)
        cprt_pkg::GRP_PEDAL: begin
          r.words.word_a = d[15:0];
          r.words.word_b = d[31:16];
          r.words.word_c = d[47:32];
          r.words.word_d = d[63:48];
        end
        cprt_pkg::GRP_CURRENT: r.words.word_a = d[15:0];
        cprt_pkg::GRP_STATUS: begin
          r.words.fault_flag = d[15:0] != '0 || d[39:32] != cprt_pkg::STATUS_OK_BYTE ||
                               d[47:40] != '0 ||
                               (d[63:56] & cprt_pkg::STATUS_FAULT_MASK) != '0;
        end
        default: begin
          r.words.fault_flag = (d[7:0] & cprt_pkg::CHANNEL_FAULT_MASK) != '0 ||
                               d[15:8] != '0;
        end
      endcase
      s.pend = 1'b0;
      s.token = s.token + 1'b1;
      s.grp = g + 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endfunction

  // Feed transactions from the outbox; predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        next_due = advance_tracker(model_st, regs, on_wire);
        due_results.push_back(next_due);
        accepted_items++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (outbox_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          on_wire = outbox_items.pop_front();
          item_if.valid      <= 1'b1;
          item_if.operation  <= on_wire.operation;
          item_if.now_ms     <= on_wire.now_ms;
          item_if.frame_id   <= on_wire.frame_id;
          item_if.frame_len  <= on_wire.frame_len;
          item_if.frame_data <= on_wire.frame_data;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction; stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          next_due = due_results.pop_front();
          check_field("request_valid", 64'(next_due.request_valid),
                      64'(result_if.request_valid));
          check_field("request_id", 64'(next_due.request_id), 64'(result_if.request_id));
          check_field("request_payload", 64'(next_due.request_payload),
                      64'(result_if.request_payload));
          check_field("reply_accepted", 64'(next_due.reply_accepted),
                      64'(result_if.reply_accepted));
          check_field("reply_group", 64'(next_due.reply_group), 64'(result_if.reply_group));
          check_field("word_a", 64'(next_due.words.word_a), 64'(result_if.word_a));
          check_field("word_b", 64'(next_due.words.word_b), 64'(result_if.word_b));
          check_field("word_c", 64'(next_due.words.word_c), 64'(result_if.word_c));
          check_field("word_d", 64'(next_due.words.word_d), 64'(result_if.word_d));
          check_field("fault_flag", 64'(next_due.words.fault_flag),
                      64'(result_if.fault_flag));
          results_checked++;
          if (next_due.request_valid) requests_seen++;
          if (next_due.reply_accepted) replies_seen++;
        end
      end
      result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Hold until everything queued has been sent and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (outbox_items.size() != 0 || item_if.valid || due_results.size() != 0);
  endtask

  task automatic write_regs(input logic en, input logic [cprt_pkg::NODE_W-1:0] loc,
                            input logic [cprt_pkg::NODE_W-1:0] rem,
                            input logic [cprt_pkg::MS_W-1:0] tmo,
                            input logic [cprt_pkg::MS_W-1:0] ivl);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= cprt_pkg::REG_POLL_ENABLE;
    cfg_data  <= cprt_pkg::CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= cprt_pkg::REG_OWN_NODE;
    cfg_data  <= cprt_pkg::CFG_DATA_W'(loc);
    @(posedge clk);
    cfg_index <= cprt_pkg::REG_REMOTE_NODE;
    cfg_data  <= cprt_pkg::CFG_DATA_W'(rem);
    @(posedge clk);
    cfg_index <= cprt_pkg::REG_REPLY_DEADLINE;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= cprt_pkg::REG_POLL_INTERVAL;
    cfg_data  <= ivl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    regs = {en, loc, rem, tmo, ivl};
    num_settings++;
  endtask

  // Queue one transaction and advance the planning copy of the tracker
  task automatic queue_item(input logic op, input logic [cprt_pkg::TIME_W-1:0] now,
                            input logic [cprt_pkg::ID_W-1:0] id,
                            input logic [cprt_pkg::LEN_W-1:0] len,
                            input logic [cprt_pkg::DATA_W-1:0] data);
    cprt_pkg::item_t it;
    it.operation  = op;
    it.now_ms     = now;
    it.frame_id   = id;
    it.frame_len  = len;
    it.frame_data = data;
    void'(advance_tracker(plan_st, regs, it));
    outbox_items.push_back(it);
    queued_total++;
  endtask

  // Ticks carry random frame fields, which the block must ignore
  task automatic tick_at(input logic [cprt_pkg::TIME_W-1:0] now);
    queue_item(cprt_pkg::OP_TICK, now, cprt_pkg::ID_W'($urandom),
               cprt_pkg::LEN_W'($urandom_range(0, 15)), {$urandom, $urandom});
  endtask

  task automatic reply_now(input logic [cprt_pkg::TIME_W-1:0] now,
                           input logic [cprt_pkg::DATA_W-1:0] data);
    queue_item(cprt_pkg::OP_FRAME, now, plan_st.reply_id, grp_len(plan_st.grp), data);
  endtask

  // Random payload; half the time a fault-free pattern for the group, maybe with one bit off
  function automatic logic [cprt_pkg::DATA_W-1:0] shaped_payload(
      input logic [cprt_pkg::GROUP_W-1:0] g);
    logic [cprt_pkg::DATA_W-1:0] d;
    int                          b;
    d = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) begin
      if (g == cprt_pkg::GRP_STATUS) begin
        d[15:0]  = '0;
        d[39:32] = cprt_pkg::STATUS_OK_BYTE;
        d[47:40] = '0;
        d[60:58] = '0;
      end else if (g == cprt_pkg::GRP_CHANNEL) begin
        d[5:1]  = '0;
        d[15:8] = '0;
      end
      if ($urandom_range(0, 2) == 0) begin
        b = $urandom_range(0, 63);
        d[b] = ~d[b];
      end
    end
    return d;
  endfunction

  // Tick late enough to expire a pending request and pass the poll interval
  task automatic poll_tick();
    logic [cprt_pkg::TIME_W-1:0] gap;
    gap = cprt_pkg::TIME_W'(regs.ivl);
    if (plan_st.pend && cprt_pkg::TIME_W'(regs.tmo) + 1 > gap)
      gap = cprt_pkg::TIME_W'(regs.tmo) + 1;
    tick_at(plan_st.last + gap + cprt_pkg::TIME_W'($urandom_range(0, 3)));
  endtask

  task automatic broken_round();
    logic [cprt_pkg::TIME_W-1:0] t;
    logic [cprt_pkg::DATA_W-1:0] d;
    int                          kind;
    poll_tick();
    t = plan_st.last + cprt_pkg::TIME_W'($urandom_range(0, regs.tmo));
    d = shaped_payload(plan_st.grp);
    kind = $urandom_range(0, 4);
    case (kind)
      0: queue_item(cprt_pkg::OP_FRAME, t,
                    plan_st.reply_id ^
                    (cprt_pkg::ID_W'(1) << $urandom_range(0, cprt_pkg::ID_W - 1)),
                    grp_len(plan_st.grp), d);
      1: queue_item(cprt_pkg::OP_FRAME, t, plan_st.reply_id,
                    cprt_pkg::LEN_W'($urandom_range(0, 15)), d);
      2: reply_now(plan_st.last + cprt_pkg::TIME_W'(regs.tmo) + 1 +
                   cprt_pkg::TIME_W'($urandom_range(0, 20)), d);
      3: begin
        reply_now(t, d);
        reply_now(t, d);
      end
      default: begin
        tick_at(plan_st.last + cprt_pkg::TIME_W'($urandom_range(0, regs.tmo)));
        reply_now(t, d);
      end
    endcase
  endtask

  // One register setting followed by a burst of mostly well-formed poll rounds
  task automatic run_phase(input logic en, input logic [cprt_pkg::NODE_W-1:0] loc,
                           input logic [cprt_pkg::NODE_W-1:0] rem,
                           input logic [cprt_pkg::MS_W-1:0] tmo,
                           input logic [cprt_pkg::MS_W-1:0] ivl, input int n,
                           input logic [cprt_pkg::TIME_W-1:0] base);
    int   start;
    int   pick;
    logic live;
    logic paused;
    wait_drained();
    write_regs(en, loc, rem, tmo, ivl);
    live = en && tmo != '0 && loc <= cprt_pkg::NODE_MAX && rem <= cprt_pkg::NODE_MAX &&
           loc != rem;
    if (counted_items < 190) begin
      src_idle_pct = 14;
      sink_idle_pct = 88;
    end else if (counted_items < 380) begin
      src_idle_pct = 88;
      sink_idle_pct = 14;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    start = queued_total;
    paused = 1'b0;
    tick_at(base);
    while (queued_total - start < n) begin
      // hold the sender once until every result is back
      if (!paused && queued_total - start >= n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        poll_tick();
        if (plan_st.pend)
          reply_now(plan_st.last + cprt_pkg::TIME_W'($urandom_range(0, regs.tmo)),
                    shaped_payload(plan_st.grp));
      end else if (pick < 88) begin
        broken_round();
      end else begin
        queue_item(1'($urandom_range(0, 1)), $urandom, cprt_pkg::ID_W'($urandom),
                   cprt_pkg::LEN_W'($urandom_range(0, 15)), {$urandom, $urandom});
      end
    end
    if (live) counted_items += queued_total - start;
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [cprt_pkg::NODE_W-1:0] loc;
    logic [cprt_pkg::NODE_W-1:0] rem;
    logic [cprt_pkg::ID_W-1:0]   stale_id;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = cprt_pkg::REG_POLL_ENABLE;
    cfg_data = '0;
    item_if.valid = 1'b0;
    item_if.operation = cprt_pkg::OP_TICK;
    item_if.now_ms = '0;
    item_if.frame_id = '0;
    item_if.frame_len = '0;
    item_if.frame_data = '0;
    result_if.ready = 1'b0;
    on_wire = '0;
    regs = '0;
    model_st = '0;
    plan_st = '0;
    src_idle_pct = 14;
    sink_idle_pct = 88;
    queued_total = 0;
    counted_items = 0;
    accepted_items = 0;
    results_checked = 0;
    requests_seen = 0;
    replies_seen = 0;
    num_settings = 0;
    mismatches = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // polling is off after reset: ignore both a tick and a frame
    tick_at(32'd0);
    reply_now(32'hFFFF_FFFF, '0);

    wait_drained();
    write_regs(1'b1, 4'd1, 4'd2, 16'd50, 16'd10);
    tick_at(32'd5);                                      // inside the poll interval
    tick_at(32'd10);                                     // pedal group request
    tick_at(32'd30);                                     // still waiting for the reply
    queue_item(cprt_pkg::OP_FRAME, 32'd31, plan_st.reply_id, 4'd15, '1);  // length above 8
    queue_item(cprt_pkg::OP_FRAME, 32'd32, '1, 4'd8, '1);  // wrong identifier
    reply_now(32'd33, '1);                               // pedal words all ones
    reply_now(32'd34, '0);                               // duplicate, nothing pending
    tick_at(32'd45);                                     // current group request
    reply_now(32'd95, 64'hDEAD_BEEF_0000_1234);          // right on the deadline
    tick_at(32'd100);                                    // status group request
    stale_id = plan_st.reply_id;
    tick_at(32'd151);                                    // expire, then request again
    queue_item(cprt_pkg::OP_FRAME, 32'd160, stale_id, 4'd8, '0);  // reply to dropped request
    reply_now(32'd201, 64'h0000_0001_0000_0000);         // healthy status
    tick_at(32'd220);                                    // channel group request
    reply_now(32'd271, 64'h0);                           // one ms late

    // node registers turned invalid while a request is pending
    wait_drained();
    write_regs(1'b1, 4'd15, 4'd2, 16'd50, 16'd10);
    tick_at(32'd400);                                    // no expiry while disabled
    tick_at(32'hFFFF_FFFF);
    reply_now(32'd230, 64'h2);                           // still accepted, channel fault

    // register extremes and each way of switching polling off
    run_phase(1'b1, 4'd0, 4'd14, 16'hFFFF, 16'hFFFF, 60, 32'hFFFF_FF00);
    run_phase(1'b0, 4'd3, 4'd4, 16'd100, 16'd10, 8, $urandom);
    run_phase(1'b1, 4'd14, 4'd0, 16'd1, 16'd0, 60, $urandom);
    run_phase(1'b1, 4'd15, 4'd2, 16'd60, 16'd5, 8, $urandom);
    run_phase(1'b1, 4'd6, 4'd15, 16'd60, 16'd5, 8, $urandom);
    run_phase(1'b1, 4'd7, 4'd7, 16'd60, 16'd5, 8, $urandom);
    run_phase(1'b1, 4'd2, 4'd9, 16'd0, 16'd5, 8, $urandom);

    // random settings until enough live traffic has gone through
    while (counted_items < 470) begin
      loc = cprt_pkg::NODE_W'($urandom_range(0, 14));
      rem = cprt_pkg::NODE_W'($urandom_range(0, 14));
      if (rem == loc) rem = (loc == 4'd14) ? 4'd0 : loc + 1'b1;
      run_phase(1'b1, loc, rem, cprt_pkg::MS_W'($urandom_range(1, 300)),
                cprt_pkg::MS_W'($urandom_range(0, 300)), 60, $urandom);
      if ($urandom_range(0, 3) == 0)
        run_phase(1'b0, loc, rem, 16'd100, 16'd10, 6, $urandom);
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Ran %0d transactions across %0d register settings, %0d results checked.",
             accepted_items, num_settings, results_checked);
    $display("Results held %0d poll requests and %0d decoded replies.",
             requests_seen, replies_seen);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cprt_pkg.sv
rtl/cprt_if.sv
rtl/cprt_cfg_regs.sv
rtl/cprt_reply_decode.sv
rtl/cprt_engine.sv
rtl/can_poll_reply_tracker_unit.sv
dv/tb_can_poll_reply_tracker_unit.sv
